>>> design/kls_pkg.sv
// ----------------------------------------------------------------------------
// kls_pkg: shared constants and types for the k-th largest selector
// Widths of the data path, depth of the cell chain and the control word that
// the top level drives into every cell.
// ----------------------------------------------------------------------------
package kls_pkg;

    localparam int MAX_K   = 16;
    localparam int IDX_W   = $clog2(MAX_K);
    localparam int RANK_W  = 5;
    localparam int DATA_W  = 32;

    // Control word broadcast to the whole chain.
    typedef struct packed {
        logic insert;   // insert the incoming word this cycle
        logic clear;    // drop all held values
    } cell_ctrl_t;

endpackage

>>> design/kls_cell.sv
// ----------------------------------------------------------------------------
// kls_cell: one compare-and-shift cell of the sorted chain
// Holds one value of the descending list. On an insert it either keeps its
// value, takes the new word, or takes its left neighbor's value.
// ----------------------------------------------------------------------------
module kls_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  kls_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [kls_pkg::DATA_W-1:0]   ins_value,
    input  logic signed [kls_pkg::DATA_W-1:0]   left_value,
    input  logic                                left_valid,
    input  logic                                left_take,
    output logic signed [kls_pkg::DATA_W-1:0]   value,
    output logic                                valid,
    output logic                                take
);

    logic signed [kls_pkg::DATA_W-1:0] value_reg;
    logic signed [kls_pkg::DATA_W-1:0] value_next;
    logic                              valid_reg;
    logic                              valid_next;

    // An empty cell or a held value below the new one opens a slot here.
    // Equal values stay ahead of the new word.
    assign take = !valid_reg || (ins_value > value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.insert && take)
        begin
            // The first taking cell receives the new word; the ones after it
            // shift the list down by one place.
            value_next = left_take ? left_value : ins_value;
            valid_next = left_take ? left_valid : 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

>>> design/kth_largest_select.sv
// ----------------------------------------------------------------------------
// kth_largest_select: k-th largest value of a streamed signed array
// A chain of compare-and-shift cells keeps the largest values of the array in
// descending order; after the last word the selected rank is reported.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                        Content
//  s_axis    in         s_tvalid s_tready s_tdata      value, last_item on s_tlast
//                       s_tlast
//  m_axis    out        m_tvalid m_tready m_tdata      kth_value, too_few on m_tuser
//                       m_tuser
//  cfg       in         cfg_we cfg_wdata               rank_k
//
//  One word is inserted into the cell chain per cycle while s_tready is high.
//  After a word with tlast the block enters a report state, in which the chosen cell is read
//  into the output register and the chain is cleared; s_tready is low then.
//  The report state waits while an earlier result still sits unread on m_axis.
//  Reset empties the chain and sets rank_k to 1; no clearing pass is needed.
//
module kth_largest_select (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,    // [31:0] value
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,    // [31:0] kth_value
    output logic                        m_tuser,    // [0] too_few
    input  logic                        cfg_we,
    input  logic [kls_pkg::RANK_W-1:0]  cfg_wdata
);

    logic [kls_pkg::RANK_W-1:0]             rank_k_reg;
    logic                                   report_reg;
    logic                                   report_next;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic [31:0]                            out_data_reg;
    logic [31:0]                            out_data_next;
    logic                                   out_few_reg;
    logic                                   out_few_next;

    kls_pkg::cell_ctrl_t                    ctrl;
    logic                                   in_fire;
    logic                                   report_done;
    logic [kls_pkg::IDX_W-1:0]              sel_idx;

    logic signed [kls_pkg::DATA_W-1:0]      cell_value [kls_pkg::MAX_K];
    logic [kls_pkg::MAX_K-1:0]              cell_valid;
    logic [kls_pkg::MAX_K-1:0]              cell_take;

    assign s_tready    = !report_reg;
    assign in_fire     = s_tvalid && s_tready;
    assign report_done = report_reg && (!out_valid_reg || m_tready);

    assign ctrl.insert = in_fire;
    assign ctrl.clear  = report_done;

    // Rank zero reads as the maximum, ranks past the chain as its last cell.
    always_comb
    begin
        if (rank_k_reg == '0)
        begin
            sel_idx = '0;
        end
        else if (rank_k_reg > kls_pkg::RANK_W'(kls_pkg::MAX_K))
        begin
            sel_idx = kls_pkg::IDX_W'(kls_pkg::MAX_K - 1);
        end
        else
        begin
            sel_idx = kls_pkg::IDX_W'(rank_k_reg - kls_pkg::RANK_W'(1));
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < kls_pkg::MAX_K; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                kls_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .ins_value  (s_tdata),
                    .left_value ('0),
                    .left_valid (1'b1),
                    .left_take  (1'b0),
                    .value      (cell_value[gi]),
                    .valid      (cell_valid[gi]),
                    .take       (cell_take[gi])
                );
            end
            else
            begin : g_body
                kls_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .ins_value  (s_tdata),
                    .left_value (cell_value[gi-1]),
                    .left_valid (cell_valid[gi-1]),
                    .left_take  (cell_take[gi-1]),
                    .value      (cell_value[gi]),
                    .valid      (cell_valid[gi]),
                    .take       (cell_take[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        report_next    = report_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_few_next   = out_few_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_fire && s_tlast)
        begin
            report_next = 1'b1;
        end
        if (report_done)
        begin
            report_next    = 1'b0;
            out_valid_next = 1'b1;
            // A rank past the number of held values means the array was short.
            out_few_next   = !cell_valid[sel_idx];
            out_data_next  = cell_valid[sel_idx] ? cell_value[sel_idx] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_k_reg    <= kls_pkg::RANK_W'(1);
            report_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                rank_k_reg <= cfg_wdata;
            end
            report_reg    <= report_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_few_reg  <= out_few_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_few_reg;

    // The held values always fill the chain from its head without gaps.
    a_valid_prefix : assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid + kls_pkg::MAX_K'(1)) & cell_valid) == '0)
        else $error("cell chain has a gap in its valid bits");

    a_last_reports : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s_tlast |=> report_reg)
        else $error("last word did not start a report");

    a_report_output : assert property (@(posedge clk) disable iff (!rst_n)
        report_done |=> m_tvalid && (cell_valid == '0))
        else $error("report did not load the output and clear the chain");

    a_few_zero : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("too_few result carries a nonzero value");

endmodule

>>> sim/kth_largest_select_test.sv
// ----------------------------------------------------------------------------
// kth_largest_select_test: self-checking bench for the k-th largest selector
// Streams signed arrays into the block under several rank settings, predicts
// each end-of-array result with a behavioral sorted list or a table entry, and
// compares every word on the result stream field by field. Both stream sides
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module kth_largest_select_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1600;
    localparam int TAIL_WORDS   = 200;
    localparam int PHASE_WORDS  = 120;
    localparam int LONG_HOLD    = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE       = 4;
    localparam int MAX_REPORTS  = 10;
    localparam int N_DIRECTED   = 15;

    typedef struct packed {
        logic signed [kls_pkg::DATA_W-1:0] kth;
        logic                              too_few;
    } rank_result_t;

    typedef struct packed {
        logic [kls_pkg::RANK_W-1:0]        rank;
        logic [kls_pkg::DATA_W-1:0]        value;
        logic                              lst;
        logic                              typed;
        logic [kls_pkg::DATA_W-1:0]        want_value;
        logic                              want_few;
    } stim_row_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [31:0]                    s_tdata;    // [31:0] value
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [31:0]                    m_tdata;    // [31:0] kth_value
    logic                           m_tuser;    // [0] too_few
    logic                           cfg_we;
    logic [kls_pkg::RANK_W-1:0]     cfg_wdata;

    // Behavioral copy of the block: descending list of the largest values.
    logic signed [kls_pkg::DATA_W-1:0] held_vals [kls_pkg::MAX_K];
    int                                held_count;
    logic [kls_pkg::RANK_W-1:0]        rank_setting;

    rank_result_t pending_results [$];
    int           mismatches;
    int           quiet_cycles;
    int           send_gap_pct;
    int           sink_gap_pct;
    bit           long_hold_req;

    // Directed arrays: extremes, rank zero and above range, duplicates, too few.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{5'd1,  32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff, 1'b0},
        '{5'd1,  32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
        '{5'd1,  32'h0000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{5'd1,  32'hffff_ffff, 1'b1, 1'b1, 32'h0,         1'b0},
        '{5'd0,  32'hffff_fffb, 1'b0, 1'b0, 32'h0,         1'b0},
        '{5'd0,  32'h0000_0003, 1'b0, 1'b0, 32'h0,         1'b0},
        '{5'd0,  32'hffff_fff9, 1'b1, 1'b0, 32'h0,         1'b0},
        '{5'd2,  32'h0000_0004, 1'b0, 1'b0, 32'h0,         1'b0},
        '{5'd2,  32'h0000_0004, 1'b0, 1'b0, 32'h0,         1'b0},
        '{5'd2,  32'h0000_0001, 1'b1, 1'b0, 32'h0,         1'b0},
        '{5'd3,  32'h0000_000a, 1'b0, 1'b0, 32'h0,         1'b0},
        '{5'd3,  32'h0000_0014, 1'b1, 1'b1, 32'h0,         1'b1},
        '{5'd31, 32'h0000_0001, 1'b1, 1'b1, 32'h0,         1'b1},
        '{5'd2,  32'h8000_0000, 1'b0, 1'b0, 32'h0,         1'b0},
        '{5'd2,  32'h7fff_ffff, 1'b1, 1'b1, 32'h8000_0000, 1'b0}
    };

    kth_largest_select dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void hold_value(logic signed [kls_pkg::DATA_W-1:0] v);
        int pos;
        int i;
        pos = 0;
        while (pos < held_count && held_vals[pos] >= v)
            pos++;
        if (pos >= kls_pkg::MAX_K)
            return;
        i = (held_count < kls_pkg::MAX_K) ? held_count : kls_pkg::MAX_K - 1;
        while (i > pos)
        begin
            held_vals[i] = held_vals[i - 1];
            i--;
        end
        held_vals[pos] = v;
        if (held_count < kls_pkg::MAX_K)
            held_count++;
    endfunction

    function automatic rank_result_t select_rank();
        rank_result_t r;
        int           k;
        k = rank_setting;
        if (k == 0)
            k = 1;
        if (k > kls_pkg::MAX_K)
            k = kls_pkg::MAX_K;
        if (held_count >= k)
        begin
            r.kth     = held_vals[k - 1];
            r.too_few = 1'b0;
        end
        else
        begin
            r.kth     = '0;
            r.too_few = 1'b1;
        end
        held_count = 0;
        return r;
    endfunction

    function automatic logic [kls_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 3))
                    0:       return 32'h7fff_ffff;
                    1:       return 32'h8000_0000;
                    2:       return '0;
                    default: return '1;
                endcase
            // A narrow range around zero gives plenty of duplicates.
            1, 2, 3: return $urandom_range(0, 16) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_word(input logic [kls_pkg::DATA_W-1:0] v, input logic lst,
                             input logic typed, input rank_result_t want);
        rank_result_t r;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        hold_value(v);
        if (lst)
        begin
            r = select_rank();
            pending_results.push_back(typed ? want : r);
        end
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clk);
        end
    endtask

    // The rank may only change while no array is in flight.
    task automatic set_rank(input logic [kls_pkg::RANK_W-1:0] r);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= r;
        @(negedge clk);
        cfg_we    <= 1'b0;
        rank_setting = r;
    endtask

    // Result side ready, with random stalls and one long hold-off.
    initial
    begin : sink_ready
        int gap;
        m_tready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if ($urandom_range(0, 99) < sink_gap_pct)
            begin
                m_tready <= 1'b0;
                gap = $urandom_range(1, 13);
                repeat (gap - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        rank_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result word: exp none, got kth_value=%0d too_few=%0b",
                             $signed(m_tdata), m_tuser);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.kth || m_tuser !== want.too_few)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"result mismatch: kth_value exp %0d got %0d, ",
                                  "too_few exp %0b got %0b"},
                                 want.kth, $signed(m_tdata), want.too_few, m_tuser);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [kls_pkg::RANK_W-1:0] phase_ranks [6];
        int           words_sent;
        int           phase_words;
        int           phase;
        int           len;
        bit           tail;
        rank_result_t want;

        phase_ranks  = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17};
        rst_n        = 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tlast      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        mismatches   = 0;
        quiet_cycles = 0;
        send_gap_pct = 0;
        sink_gap_pct = 0;
        long_hold_req = 1'b0;
        held_count   = 0;
        rank_setting = 5'd1;
        foreach (held_vals[i])
            held_vals[i] = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if ((i == 0 || directed_rows[i - 1].lst) && directed_rows[i].rank != rank_setting)
                set_rank(directed_rows[i].rank);
            want.kth     = directed_rows[i].want_value;
            want.too_few = directed_rows[i].want_few;
            send_word(directed_rows[i].value, directed_rows[i].lst,
                      directed_rows[i].typed, want);
        end

        words_sent = 0;
        phase      = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            set_rank(phase < 6 ? phase_ranks[phase]
                               : kls_pkg::RANK_W'($urandom_range(0, 31)));
            tail = (words_sent >= RANDOM_WORDS - TAIL_WORDS);
            case ($urandom_range(0, 2))
                0:       send_gap_pct = 0;
                1:       send_gap_pct = 10;
                default: send_gap_pct = 35;
            endcase
            case ($urandom_range(0, 2))
                0:       sink_gap_pct = 0;
                1:       sink_gap_pct = 10;
                default: sink_gap_pct = 35;
            endcase
            if (tail)
            begin
                send_gap_pct = 0;
                sink_gap_pct = 0;
            end
            if (phase == 3)
                long_hold_req = 1'b1;
            phase_words = 0;
            while (phase_words < PHASE_WORDS && words_sent < RANDOM_WORDS)
            begin
                // Mostly short arrays; some run past the list depth to saturate it.
                if ($urandom_range(0, 4) == 0)
                    len = $urandom_range(17, 40);
                else
                    len = $urandom_range(1, 20);
                for (int j = 0; j < len; j++)
                    send_word(pick_value(), j == len - 1, 1'b0, '0);
                phase_words += len;
                words_sent  += len;
            end
            phase++;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
